// File: design/gbk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbk_pkg : shared types and constants for the GBK glyph placer
// Request structs, configuration bundle, queued operation format, byte codes.
// ----------------------------------------------------------------------------
package gbk_pkg;

  // Input request: one string byte
  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
  } in_req_t;

  // Output request: one placed cell
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [7:0]  char_code;
    logic [24:0] font_address;
    logic [6:0]  bitmap_bytes;
  } out_req_t;

  // Window / font configuration
  typedef struct packed {
    logic [9:0]  window_left;
    logic [9:0]  window_top;
    logic [9:0]  window_width;
    logic [9:0]  window_height;
    logic [4:0]  glyph_size;
    logic [7:0]  line_gap;
    logic [23:0] font_base;
  } cfg_t;

  // Operation classes handed from the front end to the back end
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_END    = 3'd1;
  localparam logic [2:0] OP_NARROW = 3'd2;
  localparam logic [2:0] OP_BREAK  = 3'd3;
  localparam logic [2:0] OP_WIDE   = 3'd4;

  typedef struct packed {
    logic       start;
    logic [2:0] code;
    logic [7:0] data_byte;
    logic [7:0] lead;
  } op_t;

  // Operation queue geometry
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = 2;

  // Result kinds
  localparam logic [1:0] KIND_NARROW   = 2'd0;
  localparam logic [1:0] KIND_WIDE     = 2'd1;
  localparam logic [1:0] KIND_BLANK    = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [2:0] CFG_WINDOW_LEFT   = 3'd0;
  localparam logic [2:0] CFG_WINDOW_TOP    = 3'd1;
  localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_GLYPH_SIZE    = 3'd4;
  localparam logic [2:0] CFG_LINE_GAP      = 3'd5;
  localparam logic [2:0] CFG_FONT_BASE     = 3'd6;
  localparam int CFG_DATA_BITS = 24;

  // Configuration reset values
  localparam logic [9:0]  RST_WINDOW_WIDTH  = 10'd240;
  localparam logic [9:0]  RST_WINDOW_HEIGHT = 10'd320;
  localparam logic [4:0]  RST_GLYPH_SIZE    = 5'd16;
  localparam logic [7:0]  RST_LINE_GAP      = 8'd10;

  // Byte codes
  localparam logic [7:0] LEAD_THRESHOLD  = 8'h80;
  localparam logic [7:0] LEAD_MIN        = 8'h81;
  localparam logic [7:0] TRAIL_MIN       = 8'h40;
  localparam logic [7:0] TRAIL_GAP       = 8'h7f;
  localparam logic [7:0] TRAIL_HIGH_BASE = 8'h41;
  localparam logic [7:0] CODE_INVALID    = 8'hff;
  localparam logic [7:0] CHAR_LF         = 8'h0a;
  localparam logic [7:0] CHAR_CR         = 8'h0d;
  localparam logic [7:0] ROW_CELLS       = 8'd190;

  // Wide font sizes and bitmap sizes
  localparam logic [4:0] SIZE_S = 5'd12;
  localparam logic [4:0] SIZE_M = 5'd16;
  localparam logic [4:0] SIZE_L = 5'd24;
  localparam logic [6:0] CELL_BYTES_S = 7'd24;
  localparam logic [6:0] CELL_BYTES_M = 7'd32;
  localparam logic [6:0] CELL_BYTES_L = 7'd72;

  // Bitmap bytes of one wide glyph; zero when no wide font exists
  function automatic logic [6:0] cell_bytes(input logic [4:0] size);
    logic [6:0] n;
    case (size)
      SIZE_S:  n = CELL_BYTES_S;
      SIZE_M:  n = CELL_BYTES_M;
      SIZE_L:  n = CELL_BYTES_L;
      default: n = 7'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: design/gbk_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbk_front : byte classifier
// Tracks the pending lead byte and CR mark and turns bytes into operations.
// ----------------------------------------------------------------------------
module gbk_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire gbk_pkg::in_req_t in_data,
  output logic                  in_stall,
  input  wire logic             q_full,
  output logic                  push,
  output gbk_pkg::op_t          push_op
);
  import gbk_pkg::*;

  logic       lead_pending, lead_pending_next;
  logic [7:0] lead_byte, lead_byte_next;
  logic       cr_mark, cr_mark_next;
  logic       lead_p, cr_p, accept;
  logic [2:0] code;
  logic [7:0] b;

  assign b        = in_data.text_byte;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    lead_p            = in_data.string_start ? 1'b0 : lead_pending;
    cr_p              = in_data.string_start ? 1'b0 : cr_mark;
    code              = OP_NONE;
    lead_pending_next = lead_p;
    lead_byte_next    = lead_byte;
    cr_mark_next      = cr_p;
    if (b == 8'd0) begin
      code              = OP_END;
      lead_pending_next = 1'b0;
      cr_mark_next      = 1'b0;
    end else if (lead_p) begin
      code              = OP_WIDE;
      lead_pending_next = 1'b0;
    end else if (b > LEAD_THRESHOLD) begin
      lead_pending_next = 1'b1;
      lead_byte_next    = b;
      cr_mark_next      = 1'b0;
    end else if (b == CHAR_LF && cr_p) begin
      // LF of a CR-LF pair: already handled by the CR
      cr_mark_next = 1'b0;
    end else begin
      cr_mark_next = (b == CHAR_CR);
      code         = (b == CHAR_LF || b == CHAR_CR) ? OP_BREAK : OP_NARROW;
    end
  end

  assign push              = accept && (code != OP_NONE || in_data.string_start);
  assign push_op.start     = in_data.string_start;
  assign push_op.code      = code;
  assign push_op.data_byte = b;
  assign push_op.lead      = lead_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      cr_mark      <= 1'b0;
    end else if (accept) begin
      lead_pending <= lead_pending_next;
      cr_mark      <= cr_mark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_byte <= lead_byte_next;
    end
  end

endmodule
`default_nettype wire

// File: design/gbk_op_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbk_op_fifo : operation queue
// Short FIFO that decouples the classifier from the placement engine.
// ----------------------------------------------------------------------------
module gbk_op_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire gbk_pkg::op_t push_op,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output gbk_pkg::op_t      head_op
);
  import gbk_pkg::*;

  op_t               entries [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr, rd_ptr;
  logic [OPQ_AW:0]   count;
  logic              do_pop;

  assign full       = (count == (OPQ_AW + 1)'(OPQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule
`default_nettype wire

// File: design/gbk_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbk_back : placement engine
// Owns the cursor and stop flag, does wrap / bottom checks, builds results.
// ----------------------------------------------------------------------------
module gbk_back #(
  parameter int COORD_BITS = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gbk_pkg::cfg_t cfg,
  input  wire logic          op_valid,
  input  wire gbk_pkg::op_t  op,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output gbk_pkg::out_req_t  out_data
);
  import gbk_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = ((CW > 11) ? CW : 11) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] cursor_x, cursor_x_next, cursor_y, cursor_y_next;
  logic          halted, halted_next;

  logic [CW-1:0] cx0, cy0, cxw, cyw, left_c, step_c, half_c, size_c;
  logic          hl0, wrap, over, wide_ok, out_free, load_out, latch_wide;
  logic [8:0]    step;
  logic [3:0]    half;
  logic [4:0]    cellw;
  logic [6:0]    csize, csize_r, qh_i;
  logic [7:0]    ql_i;
  logic [14:0]   idx, idx_r;
  logic [20:0]   prod;
  logic [EW-1:0] px_ext, py_ext;
  logic [10:0]   pos_x_r, pos_y_r;
  out_req_t      out_next;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && op_valid && out_free;

  assign half   = cfg.glyph_size[4:1];
  assign step   = 9'(cfg.glyph_size) + 9'(cfg.line_gap);
  assign left_c = CW'(cfg.window_left);
  assign step_c = CW'(step);
  assign half_c = CW'(half);
  assign size_c = CW'(cfg.glyph_size);

  // Cursor after an optional string restart
  assign hl0 = op.start ? 1'b0 : halted;
  assign cx0 = op.start ? left_c : cursor_x;
  assign cy0 = op.start ? CW'(cfg.window_top) : cursor_y;

  // Right-edge wrap, then bottom-edge test, both compared without subtraction
  assign cellw = (op.code == OP_WIDE) ? cfg.glyph_size : {1'b0, half};
  assign wrap  = (EW'(cx0) + EW'(cellw)) >
                 (EW'(cfg.window_left) + EW'(cfg.window_width));
  assign cxw   = wrap ? left_c : cx0;
  assign cyw   = wrap ? cy0 + step_c : cy0;
  assign over  = (EW'(cyw) + EW'(cfg.glyph_size)) >
                 (EW'(cfg.window_top) + EW'(cfg.window_height));
  assign px_ext = EW'(cxw);
  assign py_ext = EW'(cyw);

  // Wide glyph code check and table index
  assign csize   = cell_bytes(cfg.glyph_size);
  assign wide_ok = (csize != 7'd0) && (op.lead >= LEAD_MIN) && (op.lead != CODE_INVALID) &&
                   (op.data_byte >= TRAIL_MIN) && (op.data_byte != CODE_INVALID);
  assign qh_i = 7'(op.lead - LEAD_MIN);
  assign ql_i = (op.data_byte < TRAIL_GAP) ? (op.data_byte - TRAIL_MIN)
                                           : (op.data_byte - TRAIL_HIGH_BASE);
  assign idx  = 15'(qh_i) * 15'(ROW_CELLS) + 15'(ql_i);

  always_comb begin
    state_next    = state;
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    halted_next   = halted;
    load_out      = 1'b0;
    latch_wide    = 1'b0;
    out_next      = '0;
    out_next.pos_x = px_ext[10:0];
    out_next.pos_y = py_ext[10:0];
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          cursor_x_next = cx0;
          cursor_y_next = cy0;
          halted_next   = hl0;
          if (!hl0) begin
            if (op.code == OP_END) begin
              halted_next = 1'b1;
            end else if (op.code == OP_NARROW || op.code == OP_BREAK ||
                         op.code == OP_WIDE) begin
              cursor_x_next = cxw;
              cursor_y_next = cyw;
              if (over) begin
                halted_next          = 1'b1;
                load_out             = 1'b1;
                out_next.result_kind = KIND_OVERFLOW;
              end else if (op.code == OP_BREAK) begin
                cursor_y_next = cyw + step_c;
                cursor_x_next = left_c + half_c;
              end else if (op.code == OP_NARROW) begin
                cursor_x_next        = cxw + half_c;
                load_out             = 1'b1;
                out_next.result_kind = KIND_NARROW;
                out_next.char_code   = op.data_byte;
              end else begin
                cursor_x_next = cxw + size_c;
                if (wide_ok) begin
                  latch_wide = 1'b1;
                  state_next = ST_MUL;
                end else begin
                  load_out             = 1'b1;
                  out_next.result_kind = KIND_BLANK;
                end
              end
            end
          end
        end
      end
      ST_MUL: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        out_next.pos_x = pos_x_r;
        out_next.pos_y = pos_y_r;
        if (out_free) begin
          load_out              = 1'b1;
          out_next.result_kind  = KIND_WIDE;
          out_next.font_address = 25'(cfg.font_base) + 25'(prod);
          out_next.bitmap_bytes = csize_r;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cursor_x  <= '0;
      cursor_y  <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      halted   <= halted_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Wide glyph datapath: index, then multiply, then base add
  always_ff @(posedge clk) begin
    if (latch_wide) begin
      idx_r   <= idx;
      csize_r <= csize;
      pos_x_r <= px_ext[10:0];
      pos_y_r <= py_ext[10:0];
    end
    if (state == ST_MUL) begin
      prod <= 21'(idx_r) * 21'(csize_r);
    end
    if (load_out) begin
      out_data <= out_next;
    end
  end

endmodule
`default_nettype wire

// File: design/gbk_text_layout_glyph_placer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbk_text_layout_glyph_placer_top : GBK / ASCII text layout glyph placer
// Places narrow and wide glyphs of a byte string in a text window and
// gives flash addresses of wide glyph bitmaps.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | into      | in_valid/in_stall  | in_req_t  (text_byte, start)
//  out     | out of    | out_valid/out_stall| out_req_t (kind, pos, code, addr)
//  cfg     | into      | cfg_write          | cfg_index, cfg_data (no wait)
//
//  The front end takes one byte per cycle into a four-entry operation queue
//  unless it is full. The back end retires one operation per cycle while its
//  output is free; a valid wide glyph keeps it busy through index, multiply
//  and base add. rst (synchronous) empties the queue, clears cursor, lead,
//  CR mark and stop flag, and loads the configuration defaults.
//  in_stall rises only while the queue is full; a held result in the output
//  register stalls the back end, not the front end.
// ----------------------------------------------------------------------------
module gbk_text_layout_glyph_placer_top #(
  parameter int COORD_BITS = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire gbk_pkg::in_req_t                     in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output gbk_pkg::out_req_t                         out_data,
  input  wire logic                                 cfg_write,
  input  wire logic [gbk_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [gbk_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import gbk_pkg::*;

  cfg_t cfg;
  logic q_full, push, op_valid, op_pop;
  op_t  push_op, head_op;

  // Config registers; user writes only with no request in flight, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_left   <= '0;
      cfg.window_top    <= '0;
      cfg.window_width  <= RST_WINDOW_WIDTH;
      cfg.window_height <= RST_WINDOW_HEIGHT;
      cfg.glyph_size    <= RST_GLYPH_SIZE;
      cfg.line_gap      <= RST_LINE_GAP;
      cfg.font_base     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_LEFT:   cfg.window_left   <= cfg_data[9:0];
        CFG_WINDOW_TOP:    cfg.window_top    <= cfg_data[9:0];
        CFG_WINDOW_WIDTH:  cfg.window_width  <= cfg_data[9:0];
        CFG_WINDOW_HEIGHT: cfg.window_height <= cfg_data[9:0];
        CFG_GLYPH_SIZE:    cfg.glyph_size    <= cfg_data[4:0];
        CFG_LINE_GAP:      cfg.line_gap      <= cfg_data[7:0];
        CFG_FONT_BASE:     cfg.font_base     <= cfg_data[23:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Front end: lead byte pairing and CR-LF folding
  gbk_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  // Decoupling queue
  gbk_op_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (op_pop),
    .head_valid (op_valid),
    .head_op    (head_op)
  );

  // Back end: cursor, edges, address generation, output register
  gbk_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (op_valid),
    .op        (head_op),
    .pop       (op_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // The engine never retires from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> op_valid)
    else $error("operation popped from empty queue");

  // Wide glyph results always carry one of the supported bitmap sizes
  a_wide_bytes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == KIND_WIDE) |->
      (out_data.bitmap_bytes == CELL_BYTES_S || out_data.bitmap_bytes == CELL_BYTES_M ||
       out_data.bitmap_bytes == CELL_BYTES_L))
    else $error("wide glyph with bad bitmap size");

  // Anything but a wide glyph has no flash read attached
  a_no_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind != KIND_WIDE) |->
      (out_data.font_address == '0 && out_data.bitmap_bytes == '0))
    else $error("flash read on a non-wide result");

  // A narrow result never carries a line break or lead byte code
  a_narrow_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.result_kind == KIND_NARROW) |->
      (out_data.char_code != '0 && out_data.char_code <= LEAD_THRESHOLD &&
       out_data.char_code != CHAR_LF && out_data.char_code != CHAR_CR))
    else $error("narrow glyph with control or lead code");
`endif

endmodule
`default_nettype wire

// File: tb/gbk_text_layout_glyph_placer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbk_text_layout_glyph_placer_checker : glyph placement scoreboard
// Watches the byte, result and register channels of the glyph placer. It
// keeps its own cursor and window state, works out the glyph that each
// accepted byte places, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module gbk_text_layout_glyph_placer_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  gbk_pkg::in_req_t                   in_data,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  gbk_pkg::out_req_t                  out_data,
  input  logic                               cfg_write,
  input  logic [gbk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gbk_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                 mismatch_count,
  output int                                 glyphs_due
);
  import gbk_pkg::*;

  cfg_t        win;
  logic [10:0] cur_x;
  logic [10:0] cur_y;
  logic        lead_pend;
  logic [7:0]  lead_val;
  logic        cr_seen;
  logic        stopped;
  out_req_t    glyph_q[$];

  initial begin
    mismatch_count = 0;
    glyphs_due = 0;
  end

  function automatic void log_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ERROR %s", $time, msg);
  endfunction

  function automatic string show(input out_req_t g);
    return $sformatf("kind=%0d x=%0d y=%0d code=%02h addr=%07h bytes=%0d",
                     g.result_kind, g.pos_x, g.pos_y, g.char_code,
                     g.font_address, g.bitmap_bytes);
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [7:0] code,
                               input logic [24:0] addr, input logic [6:0] nbytes);
    out_req_t g;
    g.result_kind  = kind;
    g.pos_x        = cur_x;
    g.pos_y        = cur_y;
    g.char_code    = code;
    g.font_address = addr;
    g.bitmap_bytes = nbytes;
    glyph_q.push_back(g);
  endfunction

  function automatic void start_line();
    cur_y = cur_y + win.glyph_size + win.line_gap;
    cur_x = win.window_left;
  endfunction

  // wrap when a cell of cell_w would cross the right edge; true when the
  // cursor is already below the last line
  function automatic bit wrap_then_bottom(input int cell_w);
    int right_edge;
    int bottom_edge;
    right_edge  = int'(win.window_left) + int'(win.window_width) - cell_w;
    bottom_edge = int'(win.window_top) + int'(win.window_height)
                  - int'(win.glyph_size);
    if (int'(cur_x) > right_edge) start_line();
    return int'(cur_y) > bottom_edge;
  endfunction

  function automatic void place_byte(input in_req_t r);
    logic [7:0] b;
    int         qh;
    int         ql;
    int         csize;
    int         addr;
    int         nbytes;
    logic [1:0] kind;
    b = r.text_byte;
    if (r.string_start) begin
      cur_x     = win.window_left;
      cur_y     = win.window_top;
      stopped   = 1'b0;
      lead_pend = 1'b0;
      cr_seen   = 1'b0;
    end
    if (stopped) return;

    if (b == 8'h00) begin
      lead_pend = 1'b0;
      cr_seen   = 1'b0;
      stopped   = 1'b1;
      return;
    end

    if (lead_pend) begin
      lead_pend = 1'b0;
      if (wrap_then_bottom(int'(win.glyph_size))) begin
        stopped = 1'b1;
        emit(KIND_OVERFLOW, 8'h00, '0, '0);
        return;
      end
      qh     = lead_val;
      ql     = b;
      kind   = KIND_BLANK;
      addr   = 0;
      nbytes = 0;
      if ((win.glyph_size == SIZE_S || win.glyph_size == SIZE_M ||
           win.glyph_size == SIZE_L) &&
          qh >= int'(LEAD_MIN) && qh != int'(CODE_INVALID) &&
          ql >= int'(TRAIL_MIN) && ql != int'(CODE_INVALID)) begin
        // bitmap rows are padded to whole bytes
        csize  = (win.glyph_size / 8 + ((win.glyph_size % 8) != 0)) * win.glyph_size;
        ql     = (ql < int'(TRAIL_GAP)) ? ql - int'(TRAIL_MIN) : ql - int'(TRAIL_HIGH_BASE);
        qh     = qh - int'(LEAD_MIN);
        addr   = int'(win.font_base) + (int'(ROW_CELLS) * qh + ql) * csize;
        nbytes = csize;
        kind   = KIND_WIDE;
      end
      emit(kind, 8'h00, addr[24:0], nbytes[6:0]);
      cur_x = cur_x + win.glyph_size;
      return;
    end

    if (b > LEAD_THRESHOLD) begin
      lead_val  = b;
      lead_pend = 1'b1;
      cr_seen   = 1'b0;
      return;
    end

    // LF right after CR: the pair already made its break
    if (b == CHAR_LF && cr_seen) begin
      cr_seen = 1'b0;
      return;
    end
    cr_seen = 1'b0;

    if (wrap_then_bottom(int'(win.glyph_size >> 1))) begin
      stopped = 1'b1;
      emit(KIND_OVERFLOW, 8'h00, '0, '0);
      return;
    end

    if (b == CHAR_LF || b == CHAR_CR) begin
      start_line();
      cr_seen = (b == CHAR_CR);
      cur_x = cur_x + (win.glyph_size >> 1);
      return;
    end

    emit(KIND_NARROW, b, '0, '0);
    cur_x = cur_x + (win.glyph_size >> 1);
  endfunction

  function automatic void check_glyph(input out_req_t got);
    out_req_t want;
    if (glyph_q.size() == 0) begin
      log_error($sformatf("result with none due: %s", show(got)));
      return;
    end
    want = glyph_q.pop_front();
    if (got.result_kind !== want.result_kind || got.pos_x !== want.pos_x ||
        got.pos_y !== want.pos_y || got.char_code !== want.char_code ||
        got.font_address !== want.font_address ||
        got.bitmap_bytes !== want.bitmap_bytes)
      log_error($sformatf("glyph mismatch\n  want %s\n  got  %s", show(want), show(got)));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win.window_left   = '0;
      win.window_top    = '0;
      win.window_width  = RST_WINDOW_WIDTH;
      win.window_height = RST_WINDOW_HEIGHT;
      win.glyph_size    = RST_GLYPH_SIZE;
      win.line_gap      = RST_LINE_GAP;
      win.font_base     = '0;
      cur_x     = '0;
      cur_y     = '0;
      lead_pend = 1'b0;
      lead_val  = '0;
      cr_seen   = 1'b0;
      stopped   = 1'b0;
      glyph_q.delete();
    end else begin
      // results come from earlier bytes, so match before predicting
      if (out_valid && !out_stall) check_glyph(out_data);
      if (in_valid && !in_stall) place_byte(in_data);
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_LEFT:   win.window_left   = cfg_data[9:0];
          CFG_WINDOW_TOP:    win.window_top    = cfg_data[9:0];
          CFG_WINDOW_WIDTH:  win.window_width  = cfg_data[9:0];
          CFG_WINDOW_HEIGHT: win.window_height = cfg_data[9:0];
          CFG_GLYPH_SIZE:    win.glyph_size    = cfg_data[4:0];
          CFG_LINE_GAP:      win.line_gap      = cfg_data[7:0];
          CFG_FONT_BASE:     win.font_base     = cfg_data[23:0];
          default: ;
        endcase
      end
    end
    glyphs_due = glyph_q.size();
  end

endmodule

// File: tb/gbk_text_layout_glyph_placer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbk_text_layout_glyph_placer_top_tb : glyph placer testbench
// Feeds mixed ASCII / GBK strings through the placer under a series of
// window and font settings, with random gaps on the byte side and random
// stalls on the result side. A separate checker predicts and compares;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module gbk_text_layout_glyph_placer_top_tb;
  import gbk_pkg::*;

  // ~1750 random bytes spread over the window settings
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 146;
  // op queue is 4 deep and the back end retires a no-result byte per cycle
  // while its output is free, so this is ample margin for trailing bytes
  localparam int DRAIN_CYCLES = 40;
  // cycles with no handshake at all before the run is called hung
  localparam int IDLE_LIMIT   = 2000;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_req_t                   in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_req_t                  out_data;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int mismatch_count;
  int glyphs_due;
  int bytes_fed;
  int quiet_cycles;
  int stall_left;
  bit idle_on;       // random gaps between requests on the byte side
  bit stall_enable;  // random stalls on the result side

  gbk_text_layout_glyph_placer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gbk_text_layout_glyph_placer_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .glyphs_due     (glyphs_due)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: hold a stall or a ready level for a random stretch, then
  // pick again. Changes only at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall  <= stall_enable && ($urandom_range(0, 99) < 35);
      stall_left = gap_len();
    end
  end

  // Hang detection: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no request moved for %0d cycles, %0d glyphs due",
               $time, IDLE_LIMIT, glyphs_due);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One byte request. Called and returns at a falling edge; valid stays
  // high across back-to-back requests, and data never moves while stalled.
  task automatic feed_byte(input logic [7:0] b, input logic s);
    in_req_t r;
    r.text_byte    = b;
    r.string_start = s;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_fed++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_window(input cfg_t c);
    write_reg(CFG_WINDOW_LEFT,   CFG_DATA_BITS'(c.window_left));
    write_reg(CFG_WINDOW_TOP,    CFG_DATA_BITS'(c.window_top));
    write_reg(CFG_WINDOW_WIDTH,  CFG_DATA_BITS'(c.window_width));
    write_reg(CFG_WINDOW_HEIGHT, CFG_DATA_BITS'(c.window_height));
    write_reg(CFG_GLYPH_SIZE,    CFG_DATA_BITS'(c.glyph_size));
    write_reg(CFG_LINE_GAP,      CFG_DATA_BITS'(c.line_gap));
    write_reg(CFG_FONT_BASE,     c.font_base);
    cfg_write <= 1'b0;
  endtask

  // Wait for every predicted glyph, then let trailing no-result bytes
  // clear the op queue before anything else touches the block.
  task automatic settle();
    in_valid <= 1'b0;
    while (glyphs_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Window settings per phase: the two extremes, the power-on layout, an
  // unsupported font size in a tiny window, then random ones.
  function automatic cfg_t pick_window(input int p);
    cfg_t c;
    c.window_left   = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 100))
                                                  : 10'($urandom_range(0, 1023));
    c.window_top    = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 100))
                                                  : 10'($urandom_range(0, 1023));
    c.window_width  = ($urandom_range(0, 9) < 3) ? 10'($urandom_range(0, 40))
                                                 : 10'($urandom_range(40, 1023));
    c.window_height = ($urandom_range(0, 9) < 3) ? 10'($urandom_range(0, 60))
                                                 : 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 4))
      0:       c.glyph_size = SIZE_S;
      1:       c.glyph_size = SIZE_M;
      2:       c.glyph_size = SIZE_L;
      default: c.glyph_size = 5'($urandom_range(12, 24));
    endcase
    c.line_gap  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 20))
                                              : 8'($urandom_range(0, 255));
    c.font_base = 24'($urandom());
    case (p)
      0: begin
        // nothing fits: every string overflows on its first cell
        c = '0;
        c.glyph_size = SIZE_S;
      end
      1: begin
        c.window_left   = 10'd1023;
        c.window_top    = 10'd1023;
        c.window_width  = 10'd1023;
        c.window_height = 10'd1023;
        c.glyph_size    = SIZE_L;
        c.line_gap      = 8'd255;
        c.font_base     = 24'hffffff;
      end
      2: begin
        c.window_left   = '0;
        c.window_top    = '0;
        c.window_width  = RST_WINDOW_WIDTH;
        c.window_height = RST_WINDOW_HEIGHT;
        c.glyph_size    = RST_GLYPH_SIZE;
        c.line_gap      = RST_LINE_GAP;
      end
      3: begin
        // no wide font at this size: wide cells come out blank
        c.window_width  = 10'($urandom_range(60, 120));
        c.window_height = 10'($urandom_range(40, 100));
        c.glyph_size    = 5'd13;
      end
      default: ;
    endcase
    return c;
  endfunction

  // One string: mostly printable ASCII and valid GBK pairs, with line
  // breaks, broken pairs, raw noise, stray terminators and restarts.
  // Stops early once the phase byte budget is used up.
  task automatic feed_string(input int limit);
    int         len;
    int         pick;
    logic       s;
    logic [7:0] lead;
    s    = ($urandom_range(0, 9) != 0);
    len  = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 30) : $urandom_range(31, 300);
    repeat (len) begin
      if (bytes_fed >= limit) break;
      pick = $urandom_range(0, 99);
      lead = 8'($urandom_range(129, 254));
      if (pick < 50) begin
        feed_byte(8'($urandom_range(32, 126)), s);
      end else if (pick < 68) begin
        feed_byte(lead, s);
        feed_byte(8'($urandom_range(64, 254)), 1'b0);
      end else if (pick < 74) begin
        feed_byte(CHAR_CR, s);
        feed_byte(CHAR_LF, 1'b0);
      end else if (pick < 78) begin
        feed_byte(CHAR_LF, s);
      end else if (pick < 82) begin
        feed_byte(CHAR_CR, s);
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0: begin
            feed_byte(CODE_INVALID, s);
            feed_byte(8'($urandom_range(1, 255)), 1'b0);
          end
          1: begin
            feed_byte(lead, s);
            feed_byte(8'($urandom_range(1, 63)), 1'b0);
          end
          default: begin
            feed_byte(lead, s);
            feed_byte(CODE_INVALID, 1'b0);
          end
        endcase
      end else if (pick < 96) begin
        feed_byte(8'($urandom_range(1, 255)), s);
      end else if (pick < 98) begin
        feed_byte(8'h00, s);
      end else begin
        // restart in the middle, possibly splitting a pair
        feed_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      s = 1'b0;
    end
    if (bytes_fed < limit && $urandom_range(0, 3) != 0) feed_byte(8'h00, s);
  endtask

  initial begin
    int phase;
    int budget;
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_WINDOW_LEFT;
    cfg_data     = '0;
    bytes_fed    = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    idle_on      = 1'b0;
    stall_enable = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed string on the power-on window layout
    feed_byte(8'h41, 1'b1);                // plain ASCII
    feed_byte(8'h01, 1'b0);                // control code prints narrow
    feed_byte(LEAD_THRESHOLD, 1'b0);       // 0x80 is narrow, not a lead
    feed_byte(LEAD_MIN, 1'b0);             // first glyph of the table
    feed_byte(TRAIL_MIN, 1'b0);
    feed_byte(8'hfe, 1'b0);                // last glyph, trail above the gap
    feed_byte(8'hfe, 1'b0);
    feed_byte(CODE_INVALID, 1'b0);         // invalid lead -> blank cell
    feed_byte(8'h50, 1'b0);
    feed_byte(8'h90, 1'b0);                // trail too low -> blank
    feed_byte(8'h3f, 1'b0);
    feed_byte(8'h90, 1'b0);                // trail 0xff -> blank
    feed_byte(CODE_INVALID, 1'b0);
    feed_byte(CHAR_CR, 1'b0);              // CR-LF makes a single break
    feed_byte(CHAR_LF, 1'b0);
    feed_byte(CHAR_LF, 1'b0);              // lone LF, next byte still placed
    feed_byte(8'h78, 1'b0);
    feed_byte(CHAR_CR, 1'b0);              // lone CR
    feed_byte(8'h79, 1'b0);
    feed_byte(8'hc4, 1'b0);                // terminator as a trail byte
    feed_byte(8'h00, 1'b0);
    feed_byte(8'h7a, 1'b0);                // stopped: ignored
    feed_byte(8'h42, 1'b1);
    feed_byte(8'hc4, 1'b0);                // restart drops the pending lead
    feed_byte(8'h43, 1'b1);

    // Random strings, one window setting per phase; every third phase
    // runs with no gaps and no stalls at all
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      load_window(pick_window(phase));
      idle_on      = (phase % 3 != 0);
      stall_enable = idle_on;
      budget = bytes_fed + PHASE_ITEMS;
      while (bytes_fed < budget) feed_string(budget);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
